[hdl/fdr_pkg.sv]
package fdr_pkg;

    // Register map of the configuration port.
    localparam logic REG_ETA_OUTSIDE = 1'b0;
    localparam logic REG_ETA_INSIDE  = 1'b1;

    // Reset index is 1.0 in Q4.12.
    localparam logic [15:0] ETA_RESET = 16'd4096;

    // Reflectance of 1.0 in Q1.15.
    localparam logic [15:0] REFL_ONE = 16'd32768;

    // Default fraction bits of the incident cosine.
    localparam int FRAC_BITS_DEF = 14;

    // Step counts of the iterative units.
    localparam int DIV_STEPS  = 32;
    localparam int SQRT_STEPS = 17;
    localparam int RAT_STEPS  = 30;

    // Data that rides along the pipeline up to the index-times-cosine products.
    typedef struct packed {
        logic        tir;
        logic [15:0] ei;
        logic [15:0] et;
        logic [16:0] ci;
    } fdr_side_t;

    // One stage of the sin_t^2 divider.
    typedef struct packed {
        fdr_side_t   side;
        logic [31:0] et2;
        logic [31:0] rem;
        logic [31:0] lo;
    } fdr_div_t;

    // One stage of the cos_t square root.
    typedef struct packed {
        fdr_side_t   side;
        logic [33:0] bits;
        logic [19:0] rem;
        logic [16:0] root;
    } fdr_sqrt_t;

    // One lane of an amplitude-ratio divider.
    typedef struct packed {
        logic [33:0] den;
        logic [33:0] rem;
        logic [30:0] q;
        logic        zero;
    } fdr_ratio_t;

    // Both ratio lanes and the flag.
    typedef struct packed {
        logic       tir;
        fdr_ratio_t r1;
        fdr_ratio_t r2;
    } fdr_rat_t;

endpackage

[hdl/fresnel_dielectric_reflectance.sv]
// Unpolarized Fresnel reflectance of a dielectric boundary, fully pipelined.
// One request per clock enters and one result per clock leaves while the output
// is not stalled. Most of the depth is in the bit-per-stage dividers (32 stages
// for the transmitted sine, 30 per amplitude ratio) and the 17-stage square
// root for cos_t. The whole pipeline moves together and holds while the output
// is stalled, so in_ready follows out_ready. Write eta_outside (index 0) and
// eta_inside (index 1) only while the pipeline is empty.
module fresnel_dielectric_reflectance
    import fdr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] cos_incident,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        reflectance,
    output logic               total_internal
);

    localparam int S_DIV  = 3;
    localparam int S_SQRT = S_DIV + DIV_STEPS + 1;
    localparam int S_PROD = S_SQRT + SQRT_STEPS + 1;
    localparam int S_RAT  = S_PROD + 1;
    localparam int S_SQR  = S_RAT + RAT_STEPS + 1;
    localparam int S_OUT  = S_SQR + 1;
    localparam int NSTG   = S_OUT + 1;

    localparam logic signed [31:0] ONE_S = 32'sd1 <<< FRAC_BITS;
    localparam int SH_L = (FRAC_BITS <= 16) ? (16 - FRAC_BITS) : 0;
    localparam int SH_R = (FRAC_BITS > 16) ? (FRAC_BITS - 16) : 0;
    localparam logic [31:0] RND = (FRAC_BITS > 16) ? (32'd1 << (FRAC_BITS - 17)) : 32'd0;

    logic [15:0]     eta_out_reg;
    logic [15:0]     eta_in_reg;
    logic            adv;
    logic [NSTG-1:0] vld_reg;

    fdr_side_t   s1_reg;
    fdr_side_t   s2_reg;
    logic [31:0] s2_ei2_reg;
    logic [31:0] s2_et2_reg;
    logic [32:0] s2_sin_reg;
    fdr_side_t   s3_reg;
    logic [31:0] s3_et2_reg;
    logic [64:0] s3_lhs_reg;
    fdr_div_t    div_reg [0:DIV_STEPS];
    fdr_sqrt_t   sq_reg  [0:SQRT_STEPS];
    logic        pr_tir_reg;
    logic [32:0] pr_p1_reg;
    logic [32:0] pr_q1_reg;
    logic [32:0] pr_p2_reg;
    logic [32:0] pr_q2_reg;
    fdr_rat_t    rat_reg [0:RAT_STEPS];
    logic        sqr_tir_reg;
    logic [61:0] sqr1_reg;
    logic [61:0] sqr2_reg;
    logic [15:0] refl_reg;
    logic        tir_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eta_out_reg <= ETA_RESET;
            eta_in_reg  <= ETA_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ETA_OUTSIDE: eta_out_reg <= cfg_data;
                REG_ETA_INSIDE:  eta_in_reg  <= cfg_data;
                default:         eta_in_reg  <= cfg_data;
            endcase
        end
    end

    // The pipeline advances as a whole unless a finished result is stalled.
    assign adv      = !vld_reg[NSTG-1] || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    // Stage 1: clamp, direction swap and rescale to 16 fraction bits.
    logic signed [31:0] cw;
    logic signed [31:0] cc;
    logic [31:0]        mag;
    logic [31:0]        q16;
    logic               pos;
    fdr_side_t          s1_next;

    always_comb
    begin
        cw = {{16{cos_incident[15]}}, cos_incident};
        cc = cw;
        if (cw > ONE_S)
        begin
            cc = ONE_S;
        end
        if (cw < -ONE_S)
        begin
            cc = -ONE_S;
        end
        pos = cc > 32'sd0;
        mag = pos ? 32'(cc) : 32'(-cc);
        if (FRAC_BITS <= 16)
        begin
            q16 = mag << SH_L;
        end
        else
        begin
            q16 = (mag + RND) >> SH_R;
        end
        if (q16 > 32'd65536)
        begin
            q16 = 32'd65536;
        end
        s1_next.tir = 1'b0;
        s1_next.ei  = pos ? eta_out_reg : eta_in_reg;
        s1_next.et  = pos ? eta_in_reg : eta_out_reg;
        s1_next.ci  = q16[16:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
        end
    end

    // Stage 2: squared indices and sin_i^2 at scale 2^32.
    logic [33:0] ci2;
    assign ci2 = s1_reg.ci * s1_reg.ci;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_reg     <= s1_reg;
            s2_ei2_reg <= s1_reg.ei * s1_reg.ei;
            s2_et2_reg <= s1_reg.et * s1_reg.et;
            s2_sin_reg <= 33'h1_0000_0000 - ci2[32:0];
        end
    end

    // Stage 3: ei^2 * sin_i^2.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_reg     <= s2_reg;
            s3_et2_reg <= s2_et2_reg;
            s3_lhs_reg <= 65'(s2_ei2_reg * s2_sin_reg);
        end
    end

    // Stage 4: total internal reflection test and divider setup.
    fdr_div_t div_init;
    always_comb
    begin
        div_init          = '0;
        div_init.side     = s3_reg;
        div_init.side.tir = s3_lhs_reg >= {1'b0, s3_et2_reg, 32'd0};
        div_init.et2      = s3_et2_reg;
        div_init.rem      = s3_lhs_reg[63:32];
        div_init.lo       = s3_lhs_reg[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_reg[0] <= div_init;
        end
    end

    // Restoring divider for sin_t^2, one quotient bit per stage.
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        logic [32:0] t;
        logic        ge;
        fdr_div_t    nxt;
        always_comb
        begin
            t       = {div_reg[k].rem, div_reg[k].lo[31]};
            ge      = t >= {1'b0, div_reg[k].et2};
            nxt     = div_reg[k];
            nxt.rem = ge ? 32'(t - {1'b0, div_reg[k].et2}) : t[31:0];
            nxt.lo  = {div_reg[k].lo[30:0], ge};
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_reg[k+1] <= nxt;
            end
        end
    end

    // Square root setup: radicand 1 - sin_t^2.
    fdr_sqrt_t sq_init;
    always_comb
    begin
        sq_init      = '0;
        sq_init.side = div_reg[DIV_STEPS].side;
        sq_init.bits = {1'b0, 33'h1_0000_0000 - {1'b0, div_reg[DIV_STEPS].lo}};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg[0] <= sq_init;
        end
    end

    // Digit-by-digit square root, one result bit per stage.
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        logic [19:0] r;
        logic [19:0] trial;
        logic        ge;
        fdr_sqrt_t   nxt;
        always_comb
        begin
            r        = {sq_reg[k].rem[17:0], sq_reg[k].bits[33:32]};
            trial    = {1'b0, sq_reg[k].root, 2'b01};
            ge       = r >= trial;
            nxt      = sq_reg[k];
            nxt.bits = {sq_reg[k].bits[31:0], 2'b00};
            nxt.rem  = ge ? (r - trial) : r;
            nxt.root = {sq_reg[k].root[15:0], ge};
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_reg[k+1] <= nxt;
            end
        end
    end

    // Index-times-cosine products.
    fdr_side_t   sd;
    logic [16:0] ct;
    assign sd = sq_reg[SQRT_STEPS].side;
    assign ct = sq_reg[SQRT_STEPS].root;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pr_tir_reg <= sd.tir;
            pr_p1_reg  <= sd.et * sd.ci;
            pr_q1_reg  <= sd.ei * ct;
            pr_p2_reg  <= sd.ei * sd.ci;
            pr_q2_reg  <= sd.et * ct;
        end
    end

    // Ratio divider setup: the top quotient bit is set only when diff equals den.
    function automatic fdr_ratio_t rat_setup(input logic [32:0] p, input logic [32:0] q);
        logic [33:0] diff;
        logic [33:0] den;
        logic        b;
        fdr_ratio_t  res;
        diff     = (p >= q) ? {1'b0, p - q} : {1'b0, q - p};
        den      = {1'b0, p} + {1'b0, q};
        b        = diff >= den;
        res.den  = den;
        res.rem  = b ? 34'd0 : diff;
        res.q    = {30'd0, b};
        res.zero = den == 34'd0;
        return res;
    endfunction

    function automatic fdr_ratio_t rat_step(input fdr_ratio_t a);
        logic [34:0] t;
        logic        ge;
        fdr_ratio_t  res;
        t       = {a.rem, 1'b0};
        ge      = t >= {1'b0, a.den};
        res     = a;
        res.rem = ge ? 34'(t - {1'b0, a.den}) : t[33:0];
        res.q   = {a.q[29:0], ge};
        return res;
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rat_reg[0].tir <= pr_tir_reg;
            rat_reg[0].r1  <= rat_setup(pr_p1_reg, pr_q1_reg);
            rat_reg[0].r2  <= rat_setup(pr_p2_reg, pr_q2_reg);
        end
    end

    // Both amplitude ratios, one quotient bit per stage.
    for (genvar k = 0; k < RAT_STEPS; k++)
    begin : g_rat
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rat_reg[k+1].tir <= rat_reg[k].tir;
                rat_reg[k+1].r1  <= rat_step(rat_reg[k].r1);
                rat_reg[k+1].r2  <= rat_step(rat_reg[k].r2);
            end
        end
    end

    // Squared ratios; a zero denominator gives a ratio of one.
    logic [30:0] rr1;
    logic [30:0] rr2;
    assign rr1 = rat_reg[RAT_STEPS].r1.zero ? 31'h4000_0000 : rat_reg[RAT_STEPS].r1.q;
    assign rr2 = rat_reg[RAT_STEPS].r2.zero ? 31'h4000_0000 : rat_reg[RAT_STEPS].r2.q;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqr_tir_reg <= rat_reg[RAT_STEPS].tir;
            sqr1_reg    <= rr1 * rr1;
            sqr2_reg    <= rr2 * rr2;
        end
    end

    // Mean, rounding to Q1.15 and saturation.
    logic [62:0] sum;
    logic [16:0] rnd;
    assign sum = {1'b0, sqr1_reg} + {1'b0, sqr2_reg} + 63'(64'd1 << 45);
    assign rnd = sum[62:46];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tir_reg <= sqr_tir_reg;
            if (sqr_tir_reg || rnd > {1'b0, REFL_ONE})
            begin
                refl_reg <= REFL_ONE;
            end
            else
            begin
                refl_reg <= rnd[15:0];
            end
        end
    end

    assign out_valid      = vld_reg[NSTG-1];
    assign reflectance    = refl_reg;
    assign total_internal = tir_reg;

    // Total internal reflection always reports full reflectance.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && total_internal |-> reflectance == REFL_ONE)
        else $error("total internal reflection without full reflectance");

    // Reflectance never exceeds one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> reflectance <= REFL_ONE)
        else $error("reflectance above one");

    // A request is taken only when the pipeline moves.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !out_valid || out_ready)
        else $error("request accepted during a stall");

    // A stalled result keeps its valid bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("stalled result dropped");

endmodule

[dv/tb_fresnel_dielectric_reflectance.sv]
module tb_fresnel_dielectric_reflectance;
    import fdr_pkg::*;

    localparam int LATENCY = 88;

    // One expected result of the block.
    typedef struct packed {
        logic [15:0] refl;
        logic        tir;
    } refl_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic               cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] cos_incident;
    logic               out_valid;
    logic               out_ready;
    logic [15:0]        reflectance;
    logic               total_internal;

    logic signed [15:0] pending_cos[$];
    refl_result_t       expected_refl[$];
    logic [15:0]        eta_out_q;
    logic [15:0]        eta_in_q;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 hold_cycles;
    bit                 pause_sender;
    int                 errors;

    fresnel_dielectric_reflectance i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cos_incident   (cos_incident),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .reflectance    (reflectance),
        .total_internal (total_internal)
    );

    always #2 clk = ~clk;

    // Bitwise integer square root, floor.
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // Amplitude ratio |p - q| / (p + q) in Q.30, one for a zero denominator.
    function automatic logic [63:0] amp_ratio(input logic [63:0] p, input logic [63:0] q);
        logic [63:0] diff;
        logic [63:0] den;
        diff = (p >= q) ? p - q : q - p;
        den = p + q;
        if (den == 0)
            return 64'd1 << 30;
        return (diff << 30) / den;
    endfunction

    // Reflectance and flag for one cosine under the current indices.
    function automatic refl_result_t fresnel_predict(input logic signed [15:0] cosv);
        refl_result_t r;
        longint       c;
        logic [63:0]  ei, et, ci, sin_i2, sin_t2, ct, r1, r2;
        logic [127:0] lhs, rhs, sum;
        c = cosv;
        if (c > 16384)
            c = 16384;
        if (c < -16384)
            c = -16384;
        if (c > 0)
        begin
            ei = eta_out_q;
            et = eta_in_q;
        end
        else
        begin
            ei = eta_in_q;
            et = eta_out_q;
            c = -c;
        end
        ci = 64'(c) << 2;
        sin_i2 = (64'd1 << 32) - ci * ci;
        lhs = 128'(ei * ei) * 128'(sin_i2);
        rhs = 128'(et * et) << 32;
        if (lhs >= rhs)
        begin
            r.refl = REFL_ONE;
            r.tir = 1'b1;
            return r;
        end
        sin_t2 = 64'(lhs / 128'(et * et));
        ct = floor_sqrt((64'd1 << 32) - sin_t2);
        r1 = amp_ratio(et * ci, ei * ct);
        r2 = amp_ratio(ei * ci, et * ct);
        sum = 128'(r1) * r1 + 128'(r2) * r2;
        sum = (sum + (128'd1 << 45)) >> 46;
        r.refl = (sum > REFL_ONE) ? REFL_ONE : sum[15:0];
        r.tir = 1'b0;
        return r;
    endfunction

    // Driver: offers queued requests, idling at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cos_incident <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_refl.push_back(fresnel_predict(cos_incident));
                void'(pending_cos.pop_front());
            end
            if (!(in_valid && !in_ready))
            begin
                if (!pause_sender && pending_cos.size() != 0
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    cos_incident <= pending_cos[0];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_refl.size() == 0)
                begin
                    $error("result with no request outstanding");
                    errors++;
                end
                else
                begin
                    if (reflectance !== expected_refl[0].refl)
                    begin
                        $error("reflectance expected %0d got %0d",
                               expected_refl[0].refl, reflectance);
                        errors++;
                    end
                    if (total_internal !== expected_refl[0].tir)
                    begin
                        $error("total_internal expected %0d got %0d",
                               expected_refl[0].tir, total_internal);
                        errors++;
                    end
                    void'(expected_refl.pop_front());
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_eta(input logic idx, input logic [15:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_ETA_OUTSIDE)
            eta_out_q = val;
        else
            eta_in_q = val;
    endtask

    // Waits until every request has been answered and the pipeline is empty.
    task automatic drain;
        while (pending_cos.size() != 0 || in_valid || expected_refl.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_cos();
        int k;
        k = $urandom_range(9);
        if (k == 0)
            return 16'($urandom);
        if (k == 1)
            return 16'($urandom_range(64)) - 16'sd16416;
        return 16'($urandom_range(32768)) - 16'sd16384;
    endfunction

    function automatic logic [15:0] rand_eta();
        int k;
        k = $urandom_range(7);
        if (k == 0)
            return 16'($urandom_range(65535, 1));
        return 16'($urandom_range(8192, 4096));
    endfunction

    // Stimulus: directed cosines under several index settings, then random phases.
    initial
    begin
        logic signed [15:0] directed[$];
        logic [15:0]        eta_pairs[$];
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_ETA_OUTSIDE;
        cfg_data = '0;
        eta_out_q = ETA_RESET;
        eta_in_q = ETA_RESET;
        send_idle_pct = 18;
        recv_idle_pct = 76;
        hold_cycles = 0;
        pause_sender = 1'b0;
        errors = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        directed = '{16'sh7fff, -16'sh8000, 16'sd16384, -16'sd16384, 16'sd16385,
                     16'sd0, 16'sd1, -16'sd1, 16'sd8192, -16'sd8192, 16'sh5555,
                     16'shaaaa, 16'sd11585};
        // Index pairs: equal, glass, reversed, extremes both ways, zero inside, both zero, zero outside.
        eta_pairs = '{16'd4096, 16'd4096, 16'd4096, 16'd6144, 16'd6144, 16'd4096,
                      16'd1, 16'd65535, 16'd65535, 16'd1, 16'd4096, 16'd0,
                      16'd0, 16'd0, 16'd0, 16'd4096};
        for (int p = 0; p < eta_pairs.size(); p += 2)
        begin
            write_eta(REG_ETA_OUTSIDE, eta_pairs[p]);
            write_eta(REG_ETA_INSIDE, eta_pairs[p + 1]);
            foreach (directed[i])
                pending_cos.push_back(directed[i]);
            drain();
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            write_eta(REG_ETA_OUTSIDE, rand_eta());
            write_eta(REG_ETA_INSIDE, rand_eta());
            if (ph == 3)
            begin
                send_idle_pct = 76;
                recv_idle_pct = 18;
            end
            if (ph == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph == 1)
                hold_cycles = 300;
            for (int i = 0; i < 200; i++)
                pending_cos.push_back(rand_cos());
            // Let the sender stop mid-phase until every result is in.
            if (ph == 2)
            begin
                while (pending_cos.size() > 100)
                    @(posedge clk);
                pause_sender = 1'b1;
                while (in_valid || expected_refl.size() != 0)
                    @(posedge clk);
                pause_sender = 1'b0;
            end
            drain();
        end

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
hdl/fdr_pkg.sv
hdl/fresnel_dielectric_reflectance.sv
dv/tb_fresnel_dielectric_reflectance.sv
